// File: hw/rtl/infix_to_postfix_converter_macros.svh
// Assertion macros for the infix to postfix converter RTL.
// Depends on nothing; included by i2p_seq, the module that carries assertions.
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define I2P_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2P_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/i2p_pkg.sv
// Package for the infix to postfix converter: token, operator, result and error codes,
// sequencer states, shared structs and the precedence function. Depends on nothing.
package i2p_pkg;

  localparam int unsigned DEFAULT_STACK_DEPTH = 16;

  localparam logic [2:0] TK_OPERAND  = 3'd0;
  localparam logic [2:0] TK_OPERATOR = 3'd1;
  localparam logic [2:0] TK_LPAREN   = 3'd2;
  localparam logic [2:0] TK_RPAREN   = 3'd3;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MOD = 3'd4;
  localparam logic [2:0] PAREN_MARK = 3'd5;

  localparam logic [1:0] OK_OPERAND  = 2'd0;
  localparam logic [1:0] OK_OPERATOR = 2'd1;
  localparam logic [1:0] OK_END      = 2'd2;
  localparam logic [1:0] OK_ERROR    = 2'd3;

  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_UNMATCHED_RP = 3'd1;
  localparam logic [2:0] ERR_UNMATCHED_LP = 3'd2;
  localparam logic [2:0] ERR_INVALID      = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW     = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ERR,
    S_FIN
  } state_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [2:0] data;
  } stk_cmd_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [2:0]  op;
    logic [31:0] ref_id;
    logic [2:0]  err;
    logic        last;
  } res_t;

  // Precedence rank: a stacked left paren ranks lowest.
  function automatic logic [1:0] prec_rank(logic [2:0] code);
    logic [1:0] rank;
    case (code) inside
      OP_MUL, OP_DIV, OP_MOD: rank = 2'd2;
      OP_ADD, OP_SUB:         rank = 2'd1;
      default:                rank = 2'd0;
    endcase
    return rank;
  endfunction

endpackage

// File: hw/rtl/i2p_stack.sv
// Operator stack of the infix to postfix converter: memory, fill count and a
// registered top entry that always matches the current count. Depends on i2p_pkg.
module i2p_stack
  import i2p_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEFAULT_STACK_DEPTH,
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1),
  localparam int unsigned AW = $clog2(STACK_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  stk_cmd_t      cmd,
  output logic [CW-1:0] count,
  output logic [2:0]    top
);

  logic [2:0]    mem [STACK_DEPTH];
  logic [CW-1:0] count_next;
  logic [CW-1:0] top_idx;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;

  always_comb begin
    count_next = count;
    if (cmd.clear) begin
      count_next = '0;
    end else if (cmd.push) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end
  end

  assign top_idx = count_next - CW'(1);
  assign raddr   = top_idx[AW-1:0];
  assign waddr   = count[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[waddr] <= cmd.data;
    end
    if (cmd.push && (waddr == raddr)) begin
      top <= cmd.data;
    end else begin
      top <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/i2p_seq.sv
// Token sequencer of the infix to postfix converter: holds the item, open paren count
// and discard flag; steps the stack one entry per cycle while emit_ok. Depends on i2p_pkg.
`include "infix_to_postfix_converter_macros.svh"
module i2p_seq
  import i2p_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEFAULT_STACK_DEPTH,
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    token_kind,
  input  logic [2:0]    operator_code,
  input  logic [31:0]   operand_ref,
  input  logic          last_token,
  input  logic [CW-1:0] stk_count,
  input  logic [2:0]    stk_top,
  input  logic          emit_ok,
  output stk_cmd_t      cmd,
  output res_t          res
);

  state_t        state;
  state_t        state_next;
  logic [2:0]    kind_r;
  logic [2:0]    op_r;
  logic [31:0]   ref_r;
  logic          last_r;
  logic [2:0]    err_r;
  logic [2:0]    err_next;
  logic [CW-1:0] paren_cnt;
  logic [CW-1:0] paren_next;
  logic          discarding;
  logic          discarding_next;

  logic stk_empty;
  logic stk_full;
  logic op_bad;
  logic op_pop;
  logic rp_pop;

  assign stk_empty = (stk_count == '0);
  assign stk_full  = (stk_count == CW'(STACK_DEPTH));
  assign op_bad    = (op_r > OP_MOD);
  assign op_pop    = !stk_empty && (prec_rank(stk_top) >= prec_rank(op_r));
  assign rp_pop    = !stk_empty && (stk_top != PAREN_MARK);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (discarding) begin
          state_next = S_IDLE;
        end else begin
          case (kind_r)
            TK_OPERAND: begin
              if (emit_ok) begin
                state_next = last_r ? S_FIN : S_IDLE;
              end
            end
            TK_OPERATOR: begin
              if (op_bad) begin
                state_next = S_ERR;
              end else if (op_pop) begin
                state_next = S_EXEC;
              end else if (stk_full) begin
                state_next = S_ERR;
              end else begin
                state_next = last_r ? S_FIN : S_IDLE;
              end
            end
            TK_LPAREN: begin
              if (stk_full) begin
                state_next = S_ERR;
              end else begin
                state_next = last_r ? S_FIN : S_IDLE;
              end
            end
            TK_RPAREN: begin
              if (paren_cnt == '0) begin
                state_next = S_ERR;
              end else if (rp_pop) begin
                state_next = S_EXEC;
              end else begin
                state_next = last_r ? S_FIN : S_IDLE;
              end
            end
            default: state_next = S_ERR;
          endcase
        end
      end
      S_ERR: begin
        if (emit_ok) begin
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        if (paren_cnt != '0) begin
          state_next = S_ERR;
        end else if (stk_empty && emit_ok) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    cmd             = '0;
    res             = '0;
    err_next        = err_r;
    paren_next      = paren_cnt;
    discarding_next = discarding;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_EXEC: begin
        if (discarding) begin
          if (last_r) begin
            discarding_next = 1'b0;
          end
        end else begin
          case (kind_r)
            TK_OPERAND: begin
              res.valid  = emit_ok;
              res.kind   = OK_OPERAND;
              res.ref_id = ref_r;
            end
            TK_OPERATOR: begin
              if (op_bad) begin
                err_next = ERR_INVALID;
              end else if (op_pop) begin
                res.valid = emit_ok;
                res.kind  = OK_OPERATOR;
                res.op    = stk_top;
                cmd.pop   = emit_ok;
              end else if (stk_full) begin
                err_next = ERR_OVERFLOW;
              end else begin
                cmd.push = 1'b1;
                cmd.data = op_r;
              end
            end
            TK_LPAREN: begin
              if (stk_full) begin
                err_next = ERR_OVERFLOW;
              end else begin
                cmd.push   = 1'b1;
                cmd.data   = PAREN_MARK;
                paren_next = paren_cnt + CW'(1);
              end
            end
            TK_RPAREN: begin
              if (paren_cnt == '0) begin
                err_next = ERR_UNMATCHED_RP;
              end else if (rp_pop) begin
                res.valid = emit_ok;
                res.kind  = OK_OPERATOR;
                res.op    = stk_top;
                cmd.pop   = emit_ok;
              end else begin
                cmd.pop    = !stk_empty;
                paren_next = paren_cnt - CW'(1);
              end
            end
            default: err_next = ERR_INVALID;
          endcase
        end
      end
      S_ERR: begin
        res.valid = emit_ok;
        res.kind  = OK_ERROR;
        res.err   = err_r;
        res.last  = 1'b1;
        if (emit_ok) begin
          cmd.clear       = 1'b1;
          paren_next      = '0;
          discarding_next = !last_r;
        end
      end
      S_FIN: begin
        if (paren_cnt != '0) begin
          err_next = ERR_UNMATCHED_LP;
        end else if (!stk_empty) begin
          res.valid = emit_ok;
          res.kind  = OK_OPERATOR;
          res.op    = stk_top;
          cmd.pop   = emit_ok;
        end else begin
          res.valid = emit_ok;
          res.kind  = OK_END;
          res.last  = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      paren_cnt  <= '0;
      discarding <= 1'b0;
      err_r      <= ERR_NONE;
    end else begin
      state      <= state_next;
      paren_cnt  <= paren_next;
      discarding <= discarding_next;
      err_r      <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= token_kind;
      op_r   <= operator_code;
      ref_r  <= operand_ref;
      last_r <= last_token;
    end
  end

  `I2P_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, stk_count <= CW'(STACK_DEPTH), "stack count above depth")
  `I2P_ASSERT_NOW(a_paren_bound, clk, rst, 1'b1, paren_cnt <= stk_count, "open parens exceed stack fill")
  `I2P_ASSERT_NOW(a_emit_slot, clk, rst, res.valid, emit_ok, "result issued while output is full")
  `I2P_ASSERT_NEXT(a_err_clears, clk, rst, res.valid && (res.kind == OK_ERROR), (stk_count == '0) && (paren_cnt == '0) && (state == S_IDLE), "error item did not clear the stack")

endmodule

// File: hw/rtl/infix_to_postfix_converter.sv
// Infix to postfix converter (shunting-yard): one token per item, postfix items out.
// Each token is taken in S_IDLE and handled in S_EXEC, which pops operators as needed;
// after the last token, S_FIN pops each remaining stack entry and issues the end item.
// Throughput: one token at a time; the stack is popped once per cycle while emit_ok.
// Reset (rst, synchronous) empties the stack, clears the paren count and discard flag.
module infix_to_postfix_converter
  import i2p_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  token_kind,
  input  logic [2:0]  operator_code,
  input  logic [31:0] operand_ref,
  input  logic        last_token,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_operator,
  output logic [31:0] out_operand_ref,
  output logic [2:0]  error_code,
  output logic        last_result
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  stk_cmd_t      cmd;
  res_t          res;
  logic [CW-1:0] stk_count;
  logic [2:0]    stk_top;
  logic          emit_ok;

  assign emit_ok = !out_valid || out_ready;

  i2p_seq #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .token_kind   (token_kind),
    .operator_code(operator_code),
    .operand_ref  (operand_ref),
    .last_token   (last_token),
    .stk_count    (stk_count),
    .stk_top      (stk_top),
    .emit_ok      (emit_ok),
    .cmd          (cmd),
    .res          (res)
  );

  i2p_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .count(stk_count),
    .top  (stk_top)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_kind        <= res.kind;
      out_operator    <= res.op;
      out_operand_ref <= res.ref_id;
      error_code      <= res.err;
      last_result     <= res.last;
    end
  end

endmodule

// File: verif/infix_to_postfix_converter_tb.sv
// Self-checking testbench for the infix to postfix converter: drives token items and
// checks every postfix item against a built-in shunting-yard scoreboard.
// Depends on i2p_pkg and the infix_to_postfix_converter RTL.
module infix_to_postfix_converter_tb;
  import i2p_pkg::*;

  localparam int unsigned STACK_DEPTH    = DEFAULT_STACK_DEPTH;
  localparam logic [2:0]  TK_INVALID     = 3'd4;
  localparam int unsigned RANDOM_ITEMS   = 100;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 40;

  typedef struct {
    logic [1:0]  kind;
    logic [2:0]  op;
    logic [31:0] ref_id;
    logic [2:0]  err;
    logic        last;
  } postfix_item_t;

  typedef struct {
    logic [2:0]  kind;
    logic [2:0]  op;
    logic [31:0] ref_id;
    logic        last_tok;
  } token_t;

  class postfix_scoreboard;
    logic [2:0]    op_stack[STACK_DEPTH];
    int unsigned   stack_cnt;
    int unsigned   paren_cnt;
    bit            discarding;
    postfix_item_t expected_q[$];
    int unsigned   fail_count;

    function new();
      stack_cnt = 0;
      paren_cnt = 0;
      discarding = 1'b0;
      fail_count = 0;
      foreach (op_stack[i]) op_stack[i] = OP_ADD;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void push_item(logic [1:0] kind, logic [2:0] op, logic [31:0] ref_id,
                            logic [2:0] err, logic last);
      postfix_item_t item;
      item.kind = kind;
      item.op = op;
      item.ref_id = ref_id;
      item.err = err;
      item.last = last;
      expected_q.push_back(item);
    endfunction

    function int rank(logic [2:0] code);
      if (code == OP_MUL || code == OP_DIV || code == OP_MOD) return 2;
      if (code == OP_ADD || code == OP_SUB) return 1;
      return 0;
    endfunction

    function void pop_out();
      stack_cnt--;
      push_item(OK_OPERATOR, op_stack[stack_cnt], '0, ERR_NONE, 1'b0);
    endfunction

    function logic [2:0] apply_token(logic [2:0] kind, logic [2:0] op, logic [31:0] ref_id);
      case (kind)
        TK_OPERAND: begin
          push_item(OK_OPERAND, '0, ref_id, ERR_NONE, 1'b0);
        end
        TK_OPERATOR: begin
          if (op > OP_MOD) return ERR_INVALID;
          while (stack_cnt > 0 && rank(op_stack[stack_cnt - 1]) >= rank(op)) pop_out();
          if (stack_cnt >= STACK_DEPTH) return ERR_OVERFLOW;
          op_stack[stack_cnt] = op;
          stack_cnt++;
        end
        TK_LPAREN: begin
          if (stack_cnt >= STACK_DEPTH) return ERR_OVERFLOW;
          op_stack[stack_cnt] = PAREN_MARK;
          stack_cnt++;
          paren_cnt++;
        end
        TK_RPAREN: begin
          if (paren_cnt == 0) return ERR_UNMATCHED_RP;
          while (stack_cnt > 0 && op_stack[stack_cnt - 1] != PAREN_MARK) pop_out();
          if (stack_cnt > 0) stack_cnt--;
          paren_cnt--;
        end
        default: return ERR_INVALID;
      endcase
      return ERR_NONE;
    endfunction

    function void note_token(logic [2:0] kind, logic [2:0] op, logic [31:0] ref_id,
                             logic last_tok);
      logic [2:0] err;
      if (discarding) begin
        if (last_tok) discarding = 1'b0;
        return;
      end
      err = apply_token(kind, op, ref_id);
      if (err == ERR_NONE && last_tok) begin
        if (paren_cnt != 0) begin
          err = ERR_UNMATCHED_LP;
        end else begin
          while (stack_cnt > 0) pop_out();
          push_item(OK_END, '0, '0, ERR_NONE, 1'b1);
        end
      end
      if (err != ERR_NONE) begin
        push_item(OK_ERROR, '0, '0, err, 1'b1);
        discarding = !last_tok;
      end
      if (err != ERR_NONE || last_tok) begin
        stack_cnt = 0;
        paren_cnt = 0;
      end
    endfunction

    task report_mismatch(string msg);
      fail_count++;
      if (fail_count <= 30) $display("MISMATCH: %s", msg);
    endtask

    task check_item(logic [1:0] kind, logic [2:0] op, logic [31:0] ref_id,
                    logic [2:0] err, logic last);
      postfix_item_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item kind=%0d op=%0d ref=%h err=%0d last=%0d",
                                  kind, op, ref_id, err, last));
        return;
      end
      want = expected_q.pop_front();
      if (kind !== want.kind || op !== want.op || ref_id !== want.ref_id ||
          err !== want.err || last !== want.last) begin
        report_mismatch($sformatf({"got kind=%0d op=%0d ref=%h err=%0d last=%0d,",
                                   " want %0d %0d %h %0d %0d"},
                                  kind, op, ref_id, err, last,
                                  want.kind, want.op, want.ref_id, want.err, want.last));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  token_kind;
  logic [2:0]  operator_code;
  logic [31:0] operand_ref;
  logic        last_token;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [2:0]  out_operator;
  logic [31:0] out_operand_ref;
  logic [2:0]  error_code;
  logic        last_result;

  postfix_scoreboard sb;
  token_t            token_q[$];
  bit                quiet_phase = 1'b0;
  bit                rx_hold_req = 1'b0;
  int unsigned       stall_cycles;

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .token_kind(token_kind),
    .operator_code(operator_code),
    .operand_ref(operand_ref),
    .last_token(last_token),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_operator(out_operator),
    .out_operand_ref(out_operand_ref),
    .error_code(error_code),
    .last_result(last_result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] rand_ref();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_tok(logic [2:0] kind, logic [2:0] op, logic [31:0] ref_id);
    token_t t;
    t.kind = kind;
    t.op = op;
    t.ref_id = ref_id;
    t.last_tok = 1'b0;
    token_q.push_back(t);
  endfunction

  function automatic void add_operand();
    add_tok(TK_OPERAND, 3'($urandom_range(0, 7)), rand_ref());
  endfunction

  function automatic void add_operator();
    add_tok(TK_OPERATOR, 3'($urandom_range(OP_ADD, OP_MOD)), $urandom);
  endfunction

  function automatic void add_paren(logic [2:0] kind);
    add_tok(kind, 3'($urandom_range(0, 7)), $urandom);
  endfunction

  function automatic void add_noise();
    add_tok(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), rand_ref());
    token_q[token_q.size() - 1].last_tok = 1'($urandom_range(0, 1));
  endfunction

  function automatic void mark_last();
    token_q[token_q.size() - 1].last_tok = 1'b1;
  endfunction

  function automatic void gen_expression(int unsigned max_len, int unsigned max_depth);
    int unsigned depth = 0;
    int unsigned count = 0;
    bit          need_operand = 1'b1;
    bit          done = 1'b0;
    while (!done) begin
      if (need_operand) begin
        if (depth < max_depth && count < max_len && $urandom_range(0, 3) == 0) begin
          add_paren(TK_LPAREN);
          depth++;
        end else begin
          add_operand();
          need_operand = 1'b0;
        end
      end else if (depth > 0 && (count >= max_len || $urandom_range(0, 2) == 0)) begin
        add_paren(TK_RPAREN);
        depth--;
      end else if (count >= max_len) begin
        done = 1'b1;
      end else begin
        add_operator();
        need_operand = 1'b1;
      end
      count++;
    end
    mark_last();
  endfunction

  function automatic void gen_nest(int unsigned depth);
    repeat (depth) add_paren(TK_LPAREN);
    add_operand();
    repeat (depth) begin
      add_operator();
      add_operand();
      add_paren(TK_RPAREN);
    end
    mark_last();
  endfunction

  // Valid stays high after the last item; the next call or wait_drained takes it over.
  task automatic send_queue();
    token_t t;
    while (token_q.size() > 0) begin
      t = token_q.pop_front();
      while (!quiet_phase && $urandom_range(0, 99) < 38) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      token_kind <= t.kind;
      operator_code <= t.op;
      operand_ref <= t.ref_id;
      last_token <= t.last_tok;
      do @(posedge clk); while (!in_ready);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= quiet_phase ? 1'b1 : ($urandom_range(0, 99) >= 38);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (in_valid && in_ready) begin
        sb.note_token(token_kind, operator_code, operand_ref, last_token);
      end
      if (out_valid && out_ready) begin
        sb.check_item(out_kind, out_operator, out_operand_ref, error_code, last_result);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned random_tokens;
    int unsigned seq_idx;
    int unsigned pick;
    int unsigned idx;
    sb = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    token_kind <= TK_OPERAND;
    operator_code <= OP_ADD;
    operand_ref <= '0;
    last_token <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // All operators, both operand extremes and a parenthesized group.
    add_tok(TK_OPERAND, OP_ADD, '0);
    add_tok(TK_OPERATOR, OP_ADD, '0);
    add_tok(TK_OPERAND, OP_ADD, '1);
    add_tok(TK_OPERATOR, OP_MUL, '0);
    add_tok(TK_OPERAND, OP_ADD, 32'd5);
    add_tok(TK_OPERATOR, OP_SUB, '0);
    add_tok(TK_LPAREN, OP_ADD, '0);
    add_tok(TK_OPERAND, OP_ADD, 32'd1);
    add_tok(TK_OPERATOR, OP_DIV, '0);
    add_tok(TK_OPERAND, OP_ADD, 32'd2);
    add_tok(TK_OPERATOR, OP_MOD, '0);
    add_tok(TK_OPERAND, OP_ADD, 32'd3);
    add_tok(TK_RPAREN, OP_ADD, '0);
    mark_last();
    // Unmatched right paren as the last token.
    add_tok(TK_RPAREN, OP_ADD, '0);
    mark_last();
    // Unmatched left paren left open at the last token.
    add_tok(TK_LPAREN, OP_ADD, '0);
    add_tok(TK_OPERAND, OP_ADD, 32'd7);
    mark_last();
    // Invalid token kind, then the rest of the expression is dropped.
    add_tok(TK_INVALID, OP_ADD, '0);
    add_tok(TK_OPERAND, OP_ADD, 32'd9);
    mark_last();
    // Invalid operator code on the last token.
    add_tok(TK_OPERATOR, 3'd7, '0);
    mark_last();
    // Unmatched right paren mid-expression, then discarding.
    add_tok(TK_RPAREN, OP_ADD, '0);
    add_tok(TK_OPERAND, OP_ADD, 32'd11);
    add_tok(TK_OPERAND, OP_ADD, 32'd12);
    mark_last();
    send_queue();
    wait_drained();

    random_tokens = 0;
    seq_idx = 0;
    while (random_tokens < RANDOM_ITEMS) begin
      quiet_phase = (seq_idx >= 3 && seq_idx < 8);
      if (seq_idx == 1) rx_hold_req = 1'b1;
      if (seq_idx % 4 == 3) wait_drained();
      pick = $urandom_range(0, 99);
      // Short expressions first, so that the quiet stretch is always reached.
      if (seq_idx < 8) pick = pick % 60;
      if (pick < 60) begin
        gen_expression($urandom_range(1, 14), $urandom_range(0, 6));
      end else if (pick < 70) begin
        gen_nest($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 1));
      end else if (pick < 85) begin
        gen_expression($urandom_range(2, 12), $urandom_range(0, 4));
        idx = $urandom_range(0, token_q.size() - 1);
        token_q[idx].kind = 3'($urandom_range(0, 7));
        token_q[idx].op = 3'($urandom_range(0, 7));
      end else begin
        repeat ($urandom_range(1, 6)) add_noise();
        mark_last();
      end
      random_tokens += token_q.size();
      send_queue();
      seq_idx++;
    end
    quiet_phase = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
